@@ rtl/core/heap_shadow_init_tracker_core_macros.svh @@
// ---------------------------------------------------------------------------
// Heap shadow init tracker assertion macros
// Concurrent assertion helpers that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef HEAP_SHADOW_INIT_TRACKER_CORE_MACROS_SVH
`define HEAP_SHADOW_INIT_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HSIT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSIT_ASSERT_SAME(lbl, ante, cons)
`define HSIT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/hsit_pkg.sv @@
// ---------------------------------------------------------------------------
// Heap shadow init tracker package
// Shared constants and codes for the tracker core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package hsit_pkg;
  localparam int MAP_DEPTH_DEF  = 8192;
  localparam int MAX_ACCESS_DEF = 64;
  localparam int ADDR_W = 48;
  localparam int LEN_W  = 16;
  localparam int RUN_W  = 6;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_FREE  = 2'd3;

  localparam logic [1:0] ST_CLEAN   = 2'd0;
  localparam logic [1:0] ST_RUN     = 2'd1;
  localparam logic [1:0] ST_OOR     = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;
endpackage

@@ rtl/core/hsit_if.sv @@
// ---------------------------------------------------------------------------
// Heap shadow init tracker channels
// Valid/ready interfaces for the request and result channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface hsit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [47:0] address;
  logic [15:0] length;
  modport source (output valid, mode, address, length, input ready);
  modport sink (input valid, mode, address, length, output ready);
endinterface

interface hsit_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] run_low;
  logic [5:0] run_high;
  logic       was_read_uninit;
  logic       last;
  modport source (output valid, status, run_low, run_high, was_read_uninit, last,
                  input ready);
  modport sink (input valid, status, run_low, run_high, was_read_uninit, last,
                output ready);
endinterface

@@ rtl/core/hsit_map_ram.sv @@
// ---------------------------------------------------------------------------
// Heap shadow init tracker map RAM
// Single write, single read synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module hsit_map_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/core/heap_shadow_init_tracker_core.sv @@
// ---------------------------------------------------------------------------
// Heap shadow init tracker core
// Tracks per-byte initialized and read-while-uninitialized bits of a heap.
// ---------------------------------------------------------------------------
// Requests arrive on in_chan (mode, address, length); results leave on
// out_chan, one per request, or one per uninitialized run for a read.
// cfg_we/cfg_wdata set the region base; write it only while idle.
// After reset the block clears both maps, one entry per cycle, and
// accepts no request during that sweep.
// A request is taken only while the core is idle. It passes a check
// state, then a RAM read state and a modify and write back state for
// each map entry it touches, then a state that posts the result. A read
// that finds uninitialized bytes walks its entries twice and then scans
// one byte per cycle, while no run result is held up by the receiver,
// to report runs. The next request is taken only once the core is back
// in idle after posting the result of the last one. When the receiver
// stalls, the result is held in the output register and the core waits
// before posting the next one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heap_shadow_init_tracker_core_macros.svh"
module heap_shadow_init_tracker_core
  import hsit_pkg::*;
#(
  parameter int MAP_DEPTH  = MAP_DEPTH_DEF,
  parameter int MAX_ACCESS = MAX_ACCESS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  hsit_in_if.sink     in_chan,
  hsit_out_if.source  out_chan
);
  localparam int IW    = $clog2(MAP_DEPTH);
  localparam int REL_W = IW + 3;
  localparam int AIW   = $clog2(MAX_ACCESS);
  localparam int UVW   = 1 << AIW;
  localparam logic [ADDR_W-1:0] SPAN = ADDR_W'(MAP_DEPTH * 8);
  localparam logic [LEN_W-1:0] MAXLEN = LEN_W'(MAX_ACCESS);
  localparam logic [IW-1:0] LAST_ENTRY = IW'(MAP_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] base_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [REL_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IW-1:0]     e_r, e_nxt, e_end_r, e_end_nxt, clr_r, clr_nxt;
  logic              pass_r, pass_nxt;
  logic [UVW-1:0]    uv_r, uv_nxt;
  logic              rd_flag_r, rd_flag_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [AIW-1:0]    i_r, i_nxt, start_r, start_nxt;
  logic              in_run_r, in_run_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        o_status_r, o_status_nxt;
  logic [5:0]        o_low_r, o_low_nxt, o_high_r, o_high_nxt;
  logic              o_rd_r, o_rd_nxt, o_last_r, o_last_nxt;

  logic              init_we, rm_we, mem_re;
  logic [IW-1:0]     waddr;
  logic [7:0]        init_wd, rm_wd, init_rd, rm_rd, mask;
  logic              out_free, emit, u_bit, n_bit;
  logic [AIW-1:0]    run_start;
  logic [UVW-1:0]    uv_rest;
  logic [REL_W-1:0]  hi_calc;
  logic [REL_W-1:0]  pos [8];

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign waddr = (state_r == S_CLEAR) ? clr_r : e_r;
  assign mem_re = (state_r == S_RD);
  assign hi_calc = off_r[REL_W-1:0] + REL_W'(len_r) - REL_W'(1);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pos[k] = {e_r, 3'(k)};
      mask[7-k] = (pos[k] >= lo_r) && (pos[k] <= hi_r);
    end
  end

  assign u_bit = uv_r[i_r];
  assign n_bit = uv_r[AIW'(i_r + 1'b1)];
  assign emit = u_bit && !n_bit;
  assign run_start = in_run_r ? start_r : i_r;
  always_comb begin
    uv_rest = uv_r;
    uv_rest[i_r] = 1'b0;
  end

  hsit_map_ram #(.DEPTH(MAP_DEPTH), .AW(IW)) u_init_ram (
    .clk(clk), .we(init_we), .waddr(waddr), .wdata(init_wd),
    .re(mem_re), .raddr(e_r), .rdata(init_rd)
  );
  hsit_map_ram #(.DEPTH(MAP_DEPTH), .AW(IW)) u_rm_ram (
    .clk(clk), .we(rm_we), .waddr(waddr), .wdata(rm_wd),
    .re(mem_re), .raddr(e_r), .rdata(rm_rd)
  );

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    len_nxt = len_r;
    off_nxt = off_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    e_nxt = e_r;
    e_end_nxt = e_end_r;
    clr_nxt = clr_r;
    pass_nxt = pass_r;
    uv_nxt = uv_r;
    rd_flag_nxt = rd_flag_r;
    stat_nxt = stat_r;
    i_nxt = i_r;
    start_nxt = start_r;
    in_run_nxt = in_run_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    o_status_nxt = o_status_r;
    o_low_nxt = o_low_r;
    o_high_nxt = o_high_r;
    o_rd_nxt = o_rd_r;
    o_last_nxt = o_last_r;
    init_we = 1'b0;
    rm_we = 1'b0;
    init_wd = 8'h00;
    rm_wd = 8'h00;
    case (state_r)
      S_CLEAR: begin
        init_we = 1'b1;
        rm_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ENTRY) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          mode_nxt = in_chan.mode;
          len_nxt = in_chan.length;
          off_nxt = in_chan.address - base_r;
          uv_nxt = '0;
          rd_flag_nxt = 1'b0;
          pass_nxt = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        lo_nxt = off_r[REL_W-1:0];
        hi_nxt = hi_calc;
        e_nxt = off_r[REL_W-1:3];
        e_end_nxt = hi_calc[REL_W-1:3];
        stat_nxt = ST_CLEAN;
        if ((mode_r inside {MODE_WRITE, MODE_READ}) && len_r > MAXLEN) begin
          stat_nxt = ST_TOOLONG;
          state_nxt = S_DONE;
        end else if (len_r == '0) begin
          state_nxt = S_DONE;
        end else if (off_r >= SPAN || ADDR_W'(len_r) > SPAN - off_r) begin
          stat_nxt = ST_OOR;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        case (mode_r)
          MODE_WRITE: begin
            init_we = 1'b1;
            rm_we = 1'b1;
            init_wd = init_rd | mask;
            rm_wd = rm_rd & ~mask;
          end
          MODE_READ: begin
            if (pass_r) begin
              rm_we = 1'b1;
              rm_wd = rm_rd | mask;
            end else begin
              for (int k = 0; k < 8; k++) begin
                if (mask[7-k]) begin
                  uv_nxt[AIW'(pos[k] - lo_r)] = !init_rd[7-k];
                end
              end
            end
          end
          MODE_QUERY: begin
            rd_flag_nxt = rd_flag_r | (|(rm_rd & mask));
          end
          default: begin
            init_we = 1'b1;
            init_wd = init_rd & ~mask;
          end
        endcase
        if (e_r == e_end_r) begin
          if (mode_r == MODE_READ && !pass_r) begin
            if (uv_nxt == '0) begin
              state_nxt = S_DONE;
            end else begin
              pass_nxt = 1'b1;
              e_nxt = lo_r[REL_W-1:3];
              state_nxt = S_RD;
            end
          end else if (mode_r == MODE_READ) begin
            i_nxt = '0;
            in_run_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          e_nxt = e_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_SCAN: begin
        if (!emit || out_free) begin
          uv_nxt = uv_rest;
          i_nxt = i_r + 1'b1;
          if (u_bit) begin
            in_run_nxt = !emit;
            start_nxt = run_start;
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
            o_status_nxt = ST_RUN;
            o_low_nxt = RUN_W'(run_start);
            o_high_nxt = RUN_W'(i_r);
            o_rd_nxt = 1'b0;
            o_last_nxt = (uv_rest == '0);
            if (uv_rest == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = stat_r;
          o_low_nxt = '0;
          o_high_nxt = '0;
          o_rd_nxt = rd_flag_r;
          o_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    len_r <= len_nxt;
    off_r <= off_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    e_r <= e_nxt;
    e_end_r <= e_end_nxt;
    pass_r <= pass_nxt;
    uv_r <= uv_nxt;
    rd_flag_r <= rd_flag_nxt;
    stat_r <= stat_nxt;
    i_r <= i_nxt;
    start_r <= start_nxt;
    in_run_r <= in_run_nxt;
    o_status_r <= o_status_nxt;
    o_low_r <= o_low_nxt;
    o_high_r <= o_high_nxt;
    o_rd_r <= o_rd_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.status = o_status_r;
  assign out_chan.run_low = o_low_r;
  assign out_chan.run_high = o_high_r;
  assign out_chan.was_read_uninit = o_rd_r;
  assign out_chan.last = o_last_r;

  `HSIT_ASSERT_SAME(a_we_state, init_we || rm_we, state_r == S_MOD || state_r == S_CLEAR)
  `HSIT_ASSERT_NEXT(a_accept_check, in_chan.valid && in_chan.ready, state_r == S_CHECK)
  `HSIT_ASSERT_NEXT(a_scan_emit, state_r == S_SCAN && emit && out_free, out_chan.valid && out_chan.status == ST_RUN)
endmodule

@@ sim/heap_shadow_init_tracker_core_tb.sv @@
// ---------------------------------------------------------------------------
// Heap shadow init tracker core testbench
// Drives write, read, query and free requests over several region bases and
// checks every result transaction against an in-bench shadow-map predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module heap_shadow_init_tracker_core_tb
  import hsit_pkg::*;
();

  localparam int SPAN = MAP_DEPTH_DEF * 8;
  localparam int IDLE_LIMIT = 100000;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] run_low;
    logic [5:0] run_high;
    logic       was_read_uninit;
    logic       last;
  } result_t;

  class ShadowScoreboard;
    bit          init_bits[SPAN];
    bit          read_bits[SPAN];
    logic [47:0] base;
    result_t     pending_q[$];
    int          errors;
    int          results_seen;
    int          runs_seen;

    function void set_base(logic [47:0] value);
      base = value;
    endfunction

    function void queue_result(result_t r);
      pending_q = {pending_q, r};
    endfunction

    function void push_one(logic [1:0] status, bit rd);
      result_t r;
      r = '{status: status, run_low: 6'd0, run_high: 6'd0, was_read_uninit: rd,
            last: 1'b1};
      queue_result(r);
    endfunction

    function void note_request(logic [1:0] mode, logic [47:0] addr, logic [15:0] len);
      logic [47:0] off;
      longint      o;
      bit          uninit[64];
      bit          any;
      bit          in_run;
      int          start;
      result_t     r;
      if ((mode inside {MODE_WRITE, MODE_READ}) && len > MAX_ACCESS_DEF) begin
        push_one(ST_TOOLONG, 0);
        return;
      end
      if (len == 0) begin
        push_one(ST_CLEAN, 0);
        return;
      end
      off = addr - base;
      o = longint'(off);
      if (o >= SPAN || longint'(len) > SPAN - o) begin
        push_one(ST_OOR, 0);
        return;
      end
      case (mode)
        MODE_WRITE: begin
          for (int i = 0; i < len; i++) begin
            init_bits[o + i] = 1;
            read_bits[o + i] = 0;
          end
          push_one(ST_CLEAN, 0);
        end
        MODE_READ: begin
          any = 0;
          for (int i = 0; i < len; i++) begin
            uninit[i] = !init_bits[o + i];
            any |= uninit[i];
          end
          if (!any) begin
            push_one(ST_CLEAN, 0);
            return;
          end
          for (int i = 0; i < len; i++) read_bits[o + i] = 1;
          in_run = 0;
          start = 0;
          for (int i = 0; i < len; i++) begin
            if (uninit[i] && !in_run) begin
              in_run = 1;
              start = i;
            end
            if (in_run && (i + 1 == len || !uninit[i + 1])) begin
              r = '{status: ST_RUN, run_low: start[5:0], run_high: i[5:0],
                    was_read_uninit: 1'b0, last: 1'b0};
              queue_result(r);
              in_run = 0;
            end
          end
          pending_q[pending_q.size() - 1].last = 1'b1;
        end
        MODE_QUERY: begin
          any = 0;
          for (int i = 0; i < len; i++) any |= read_bits[o + i];
          push_one(ST_CLEAN, any);
        end
        default: begin
          for (int i = 0; i < len; i++) init_bits[o + i] = 0;
          push_one(ST_CLEAN, 0);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status == ST_RUN) runs_seen++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.run_low !== exp.run_low) begin
        $error("run_low: expected %0d, actual %0d", exp.run_low, got.run_low);
        errors++;
      end
      if (got.run_high !== exp.run_high) begin
        $error("run_high: expected %0d, actual %0d", exp.run_high, got.run_high);
        errors++;
      end
      if (got.was_read_uninit !== exp.was_read_uninit) begin
        $error("was_read_uninit: expected %0d, actual %0d", exp.was_read_uninit,
               got.was_read_uninit);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, actual %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [47:0] cfg_wdata;
  hsit_in_if   in_if();
  hsit_out_if  out_if();

  ShadowScoreboard sb;
  int  idle_cycles;
  int  requests_sent;
  int  big_ranges;
  bit  stall_free;
  int  stall_left;
  int  mode_left;

  heap_shadow_init_tracker_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      sb.check_result('{status: out_if.status, run_low: out_if.run_low,
                        run_high: out_if.run_high,
                        was_read_uninit: out_if.was_read_uninit,
                        last: out_if.last});
    end
    if (mode_left == 0) begin
      stall_free = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!stall_free && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [1:0] mode, logic [47:0] addr, logic [15:0] len);
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.address <= addr;
    in_if.length  <= len;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(mode, addr, len);
    requests_sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_base(logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_base(value);
  endtask

  task automatic random_request(int k);
    int          sel;
    logic [1:0]  mode;
    logic [47:0] off;
    logic [15:0] len;
    sel  = $urandom_range(0, 99);
    mode = 2'($urandom_range(0, 3));
    if (sel < 4) begin
      off = 48'({$urandom(), $urandom()});
      len = 16'($urandom());
    end else if (sel < 12) begin
      off = 48'(SPAN - 80 + $urandom_range(0, 100));
      len = 16'($urandom_range(0, 70));
    end else begin
      off = 48'($urandom_range(0, 511));
      if (mode inside {MODE_WRITE, MODE_READ})
        len = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(1, 16));
      else
        len = 16'($urandom_range(0, 40));
    end
    if (sel == 50 && big_ranges < 3 && mode >= MODE_QUERY) begin
      off = 48'($urandom_range(0, 7));
      len = 16'(16'hFFF0 + $urandom_range(0, 7));
      big_ranges++;
    end
    send_request(mode, sb.base + off, len);
    if (k == 30) begin
      drain_results();
    end else if ($urandom_range(0, 5) == 0) begin
      pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [47:0] bases[4];
    sb = new;
    stall_free = 0;
    stall_left = 0;
    mode_left = 0;
    idle_cycles = 0;
    requests_sent = 0;
    big_ranges = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_WRITE;
    in_if.address = '0;
    in_if.length = '0;
    out_if.ready = 1'b0;
    sb.set_base('0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_base(48'd0);

    send_request(MODE_WRITE, 48'd0, 16'd8);
    send_request(MODE_READ, 48'd0, 16'd16);
    send_request(MODE_QUERY, 48'd0, 16'd16);
    send_request(MODE_WRITE, 48'd8, 16'd8);
    send_request(MODE_QUERY, 48'd8, 16'd8);
    send_request(MODE_READ, 48'd0, 16'd16);
    for (int k = 0; k < 16; k++) send_request(MODE_WRITE, 48'(257 + 2 * k), 16'd1);
    send_request(MODE_READ, 48'd256, 16'd64);
    send_request(MODE_FREE, 48'd260, 16'd4);
    send_request(MODE_READ, 48'd256, 16'd8);
    for (int m = 0; m < 4; m++) send_request(2'(m), 48'd100, 16'd0);
    send_request(MODE_READ, 48'd0, 16'd65);
    send_request(MODE_WRITE, 48'd0, 16'hFFFF);
    send_request(MODE_WRITE, 48'(SPAN - 1), 16'd1);
    send_request(MODE_READ, 48'(SPAN - 1), 16'd2);
    send_request(MODE_WRITE, 48'(SPAN), 16'd1);
    send_request(MODE_READ, 48'hFFFF_FFFF_FFFF, 16'd4);
    send_request(MODE_QUERY, 48'd0, 16'hFFFF);
    send_request(MODE_FREE, 48'd0, 16'hFFFF);
    send_request(MODE_WRITE, 48'(SPAN - 64), 16'd64);
    drain_results();

    bases[0] = 48'hFFFF_FFFF_FFFF;
    bases[1] = 48'({$urandom(), $urandom()});
    bases[2] = 48'h0000_0000_1000;
    bases[3] = 48'd0;
    for (int p = 0; p < 4; p++) begin
      write_base(bases[p]);
      for (int k = 0; k < 55; k++) random_request(k);
      drain_results();
    end

    pause_sender(50);
    $display("Covered %0d requests over five region bases: %0d results, %0d runs.",
             requests_sent, sb.results_seen, sb.runs_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
